// ===== src/bdt_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, word types and address helper for the bounded distance transform.
package bdt_pkg;

   localparam int MAX_ROWS      = 256;
   localparam int MAX_COLS      = 256;
   localparam int SEARCH_RADIUS = 50;

   localparam int COORD_W    = 8;
   localparam int CFG_SIZE_W = 9;
   localparam int RES_W      = 16;
   localparam int DIST_W     = 22;
   localparam int DIST_MAX   = (1 << DIST_W) - 1;

   localparam int ROW_AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   localparam int RAD_W = $clog2(SEARCH_RADIUS + 1);
   localparam int CAP2  = SEARCH_RADIUS * SEARCH_RADIUS;
   localparam int D2_W  = $clog2(CAP2 + 1);
   localparam int DD_W  = $clog2(2 * CAP2 + 1);

   localparam int W_A    = (CFG_SIZE_W > COORD_W) ? CFG_SIZE_W : COORD_W;
   localparam int W_B    = (ROW_AW > COL_AW) ? ROW_AW : COL_AW;
   localparam int W_C    = (W_A > W_B) ? W_A : W_B;
   localparam int W_D    = (W_C > RAD_W) ? W_C : RAD_W;
   localparam int SCAN_W = W_D + 3;

   localparam int P1_W      = D2_W + RES_W;
   localparam int P2_W      = D2_W + 2 * RES_W;
   localparam int ROOT_HALF = (P2_W + 1) / 2;
   localparam int ROOT_W    = (ROOT_HALF > DIST_W) ? ROOT_HALF : DIST_W;
   localparam int ITER_W    = $clog2(ROOT_W + 1);

   localparam int CSR_AW     = 4;
   localparam int CSR_DW     = 32;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_MAP_ROWS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_COLS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RESOLUTION = 2'd2;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic               action;
      logic [COORD_W-1:0] cell_row;
      logic [COORD_W-1:0] cell_col;
      logic               is_free;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance_q8;
      logic              capped;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [COORD_W-1:0]    row;
      logic [COORD_W-1:0]    col;
      logic [CFG_SIZE_W-1:0] map_rows;
      logic [CFG_SIZE_W-1:0] map_cols;
   } query_type;

   typedef struct packed {
      logic            done;
      logic [D2_W-1:0] best;
   } scan_result_type;

   function automatic logic [MEM_AW-1:0] addr_of(input logic [SCAN_W-1:0] r,
                                                  input logic [SCAN_W-1:0] c);
      return MEM_AW'(r * MAX_COLS + c);
   endfunction

endpackage

// ===== src/bdt_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module bdt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/bdt_scan.sv =====
`timescale 1ns / 1ps
// Window sequencer: walks the search window one mask read per cycle, keeps the nearest obstacle.
module bdt_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  bdt_pkg::query_type            query,
   output logic [bdt_pkg::MEM_AW-1:0]    rd_addr,
   input  logic                          rd_data,
   output bdt_pkg::scan_result_type      result
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;

   localparam int SW = bdt_pkg::SCAN_W;
   localparam int RW = bdt_pkg::RAD_W;

   localparam logic signed [RW:0] RAD_POS = (RW + 1)'(bdt_pkg::SEARCH_RADIUS);
   localparam logic signed [RW:0] RAD_NEG = (RW + 1)'(-bdt_pkg::SEARCH_RADIUS);

   logic [1:0]                   state_ff, state_in;
   logic signed [SW-1:0]         row_ff, row_in, col_ff, col_in;
   logic signed [SW-1:0]         rows_ff, rows_in, cols_ff, cols_in;
   logic                         in_map_ff, in_map_in;
   logic signed [RW:0]           dr_ff, dr_in, dc_ff, dc_in;
   logic                         pend_ok_ff, pend_ok_in;
   logic [bdt_pkg::DD_W-1:0]     pend_d2_ff, pend_d2_in;
   logic [bdt_pkg::D2_W-1:0]     best_ff, best_in;
   logic                         done_ff, done_in;

   logic signed [SW-1:0]         q_row, q_col, q_rows, q_cols, q_rows_raw, q_cols_raw;
   logic signed [SW-1:0]         r, c;
   logic signed [RW:0]           adr_s, adc_s;
   logic [RW-1:0]                adr, adc;
   logic [2*RW-1:0]              sq_r, sq_c;
   logic [bdt_pkg::DD_W-1:0]     d2;
   logic                         cell_ok, last_cell;

   always_comb begin
      q_row      = SW'($signed({1'b0, query.row}));
      q_col      = SW'($signed({1'b0, query.col}));
      q_rows_raw = SW'($signed({1'b0, query.map_rows}));
      q_cols_raw = SW'($signed({1'b0, query.map_cols}));
      if (query.map_rows == '0) begin
         q_rows = SW'(1);
      end else if (q_rows_raw > SW'(bdt_pkg::MAX_ROWS)) begin
         q_rows = SW'(bdt_pkg::MAX_ROWS);
      end else begin
         q_rows = q_rows_raw;
      end
      if (query.map_cols == '0) begin
         q_cols = SW'(1);
      end else if (q_cols_raw > SW'(bdt_pkg::MAX_COLS)) begin
         q_cols = SW'(bdt_pkg::MAX_COLS);
      end else begin
         q_cols = q_cols_raw;
      end

      r = row_ff + SW'(dr_ff);
      c = col_ff + SW'(dc_ff);
      cell_ok = in_map_ff && !r[SW-1] && (r < rows_ff) && !c[SW-1] && (c < cols_ff);

      adr_s = dr_ff[RW] ? -dr_ff : dr_ff;
      adc_s = dc_ff[RW] ? -dc_ff : dc_ff;
      adr   = adr_s[RW-1:0];
      adc   = adc_s[RW-1:0];
      sq_r  = adr * adr;
      sq_c  = adc * adc;
      d2    = bdt_pkg::DD_W'(sq_r) + bdt_pkg::DD_W'(sq_c);

      last_cell = (dr_ff == RAD_POS) && (dc_ff == RAD_POS);
      rd_addr   = bdt_pkg::addr_of(r, c);
   end

   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      rows_in    = rows_ff;
      cols_in    = cols_ff;
      in_map_in  = in_map_ff;
      dr_in      = dr_ff;
      dc_in      = dc_ff;
      pend_ok_in = 1'b0;
      pend_d2_in = d2;
      best_in    = best_ff;
      done_in    = 1'b0;

      // fold the word read last cycle into the running minimum
      if (pend_ok_ff && !rd_data && (pend_d2_ff < bdt_pkg::DD_W'(best_ff))) begin
         best_in = bdt_pkg::D2_W'(pend_d2_ff);
      end

      case (state_ff)
         S_IDLE: begin
            if (query.start) begin
               row_in    = q_row;
               col_in    = q_col;
               rows_in   = q_rows;
               cols_in   = q_cols;
               in_map_in = (q_row < q_rows) && (q_col < q_cols);
               dr_in     = RAD_NEG;
               dc_in     = RAD_NEG;
               best_in   = bdt_pkg::D2_W'(bdt_pkg::CAP2);
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            pend_ok_in = cell_ok;
            if (last_cell) begin
               state_in = S_DRAIN;
            end else if (dc_ff == RAD_POS) begin
               dc_in = RAD_NEG;
               dr_in = dr_ff + (RW + 1)'(1);
            end else begin
               dc_in = dc_ff + (RW + 1)'(1);
            end
         end
         S_DRAIN: begin
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pend_ok_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pend_ok_ff <= pend_ok_in;
         done_ff    <= done_in;
      end
      row_ff     <= row_in;
      col_ff     <= col_in;
      rows_ff    <= rows_in;
      cols_ff    <= cols_in;
      in_map_ff  <= in_map_in;
      dr_ff      <= dr_in;
      dc_ff      <= dc_in;
      pend_d2_ff <= pend_d2_in;
      best_ff    <= best_in;
   end

   assign result.done = done_ff;
   assign result.best = best_ff;

endmodule

// ===== src/bdt_root.sv =====
`timescale 1ns / 1ps
// Scaling and root unit: shared multiplier for best*res*res, then a bit-pair square root.
module bdt_root (
   input  logic                          clock,
   input  logic                          reset,
   input  bdt_pkg::scan_result_type      scan,
   input  logic [bdt_pkg::RES_W-1:0]     resolution,
   output logic                          rsp_valid,
   output bdt_pkg::rsp_type              rsp_payload
);

   localparam logic [1:0] R_IDLE = 2'd0;
   localparam logic [1:0] R_MUL1 = 2'd1;
   localparam logic [1:0] R_MUL2 = 2'd2;
   localparam logic [1:0] R_ROOT = 2'd3;

   localparam int RT = bdt_pkg::ROOT_W;

   logic [1:0]                     state_ff, state_in;
   logic [bdt_pkg::P1_W-1:0]       op_ff, op_in;
   logic [2*RT-1:0]                rad_ff, rad_in;
   logic [RT:0]                    rem_ff, rem_in;
   logic [RT-1:0]                  root_ff, root_in;
   logic [bdt_pkg::ITER_W-1:0]     cnt_ff, cnt_in;
   logic                           capped_ff, capped_in;
   logic                           valid_ff, valid_in;
   logic [bdt_pkg::DIST_W-1:0]     dist_ff, dist_in;

   logic [bdt_pkg::P2_W-1:0]       prod;
   logic [RT+2:0]                  cur, trial;
   logic [RT:0]                    rem_next;
   logic [RT-1:0]                  root_next;

   always_comb begin
      prod  = op_ff * resolution;
      cur   = {rem_ff, rad_ff[2*RT-1 -: 2]};
      trial = {1'b0, root_ff, 2'b01};
      if (cur >= trial) begin
         rem_next  = (RT + 1)'(cur - trial);
         root_next = {root_ff[RT-2:0], 1'b1};
      end else begin
         rem_next  = (RT + 1)'(cur);
         root_next = {root_ff[RT-2:0], 1'b0};
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      cnt_in    = cnt_ff;
      capped_in = capped_ff;
      valid_in  = 1'b0;
      dist_in   = dist_ff;

      case (state_ff)
         R_IDLE: begin
            if (scan.done) begin
               op_in     = bdt_pkg::P1_W'(scan.best);
               capped_in = (scan.best == bdt_pkg::D2_W'(bdt_pkg::CAP2));
               state_in  = R_MUL1;
            end
         end
         R_MUL1: begin
            op_in    = bdt_pkg::P1_W'(prod);
            state_in = R_MUL2;
         end
         R_MUL2: begin
            rad_in   = (2 * RT)'(prod);
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = R_ROOT;
         end
         R_ROOT: begin
            rad_in  = {rad_ff[2*RT-3:0], 2'b00};
            rem_in  = rem_next;
            root_in = root_next;
            cnt_in  = cnt_ff + bdt_pkg::ITER_W'(1);
            if (cnt_ff == bdt_pkg::ITER_W'(RT - 1)) begin
               valid_in = 1'b1;
               if (root_next > RT'(bdt_pkg::DIST_MAX)) begin
                  dist_in = bdt_pkg::DIST_W'(bdt_pkg::DIST_MAX);
               end else begin
                  dist_in = root_next[bdt_pkg::DIST_W-1:0];
               end
               state_in = R_IDLE;
            end
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      op_ff     <= op_in;
      rad_ff    <= rad_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      cnt_ff    <= cnt_in;
      capped_ff <= capped_in;
      dist_ff   <= dist_in;
   end

   assign rsp_valid               = valid_ff;
   assign rsp_payload.distance_q8 = dist_ff;
   assign rsp_payload.capped      = capped_ff;

endmodule

// ===== src/bounded_distance_transform_top.sv =====
`timescale 1ns / 1ps
// Top level: register port, occupancy mask RAM, window scan and root unit.
//
// Request word: req_payload, taken at a clock edge with start high and busy low.
// A write word (action 0) stores one mask bit in that cycle; busy stays low, so
// writes may follow each other every cycle.
// A query word (action 1) raises busy. The scan walks the (2R+1)^2 window of
// radius R one mask read per cycle, then the shared multiplier scales the best
// squared distance and the square root yields one result bit per cycle. When it
// is done, rsp_valid rises and the word on rsp_payload is taken at the next edge;
// busy drops the cycle after, so a new query is taken only after that result.
// One query in flight at a time; the mask RAM read port sets the pace.
// Results cannot be held off: the receiver must take the word in the strobe cycle.
// Registers (map_rows, map_cols, resolution_q8) sit at byte addresses 0, 4, 8,
// written with an APB-style access; pready is tied high. The user must write
// them only while busy is low; the block does not enforce it. Reset: registers
// return to 256, 256, 256 and the sequencers go idle. The mask is not cleared;
// every cell must be written before a query relies on it.
module bounded_distance_transform_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  bdt_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   output bdt_pkg::rsp_type                rsp_payload,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bdt_pkg::CSR_AW-1:0]      paddr,
   input  logic [bdt_pkg::CSR_DW-1:0]      pwdata,
   output logic [bdt_pkg::CSR_DW-1:0]      prdata,
   output logic                            pready
);

   localparam int SW = bdt_pkg::SCAN_W;

   logic [bdt_pkg::CFG_SIZE_W-1:0] map_rows_ff, map_rows_in;
   logic [bdt_pkg::CFG_SIZE_W-1:0] map_cols_ff, map_cols_in;
   logic [bdt_pkg::RES_W-1:0]      res_ff, res_in;
   logic                           busy_ff, busy_in;

   logic                           csr_wr;
   logic [bdt_pkg::CSR_IDX_W-1:0]  csr_idx;
   logic                           accept, accept_query, ram_we, in_store;
   logic [bdt_pkg::MEM_AW-1:0]     ram_waddr, ram_raddr;
   logic                           ram_rdata;
   logic [SW-1:0]                  w_row, w_col;
   bdt_pkg::query_type             query;
   bdt_pkg::scan_result_type       scan_res;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[bdt_pkg::CSR_IDX_W+1:2];

   always_comb begin
      map_rows_in = map_rows_ff;
      map_cols_in = map_cols_ff;
      res_in      = res_ff;
      prdata      = '0;
      if (csr_wr) begin
         case (csr_idx)
            bdt_pkg::REG_MAP_ROWS:   map_rows_in = pwdata[bdt_pkg::CFG_SIZE_W-1:0];
            bdt_pkg::REG_MAP_COLS:   map_cols_in = pwdata[bdt_pkg::CFG_SIZE_W-1:0];
            bdt_pkg::REG_RESOLUTION: res_in      = pwdata[bdt_pkg::RES_W-1:0];
            default: ;
         endcase
      end
      case (csr_idx)
         bdt_pkg::REG_MAP_ROWS:   prdata = bdt_pkg::CSR_DW'(map_rows_ff);
         bdt_pkg::REG_MAP_COLS:   prdata = bdt_pkg::CSR_DW'(map_cols_ff);
         bdt_pkg::REG_RESOLUTION: prdata = bdt_pkg::CSR_DW'(res_ff);
         default:                 prdata = '0;
      endcase
   end

   always_comb begin
      accept       = start && !busy_ff;
      accept_query = accept && (req_payload.action == bdt_pkg::ACT_QUERY);
      w_row        = SW'(req_payload.cell_row);
      w_col        = SW'(req_payload.cell_col);
      in_store     = (w_row < SW'(bdt_pkg::MAX_ROWS)) && (w_col < SW'(bdt_pkg::MAX_COLS));
      ram_we       = accept && (req_payload.action == bdt_pkg::ACT_WRITE) && in_store;
      ram_waddr    = bdt_pkg::addr_of(w_row, w_col);

      busy_in = busy_ff;
      if (accept_query) begin
         busy_in = 1'b1;
      end else if (rsp_valid) begin
         busy_in = 1'b0;
      end

      query.start    = accept_query;
      query.row      = req_payload.cell_row;
      query.col      = req_payload.cell_col;
      query.map_rows = map_rows_ff;
      query.map_cols = map_cols_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_rows_ff <= bdt_pkg::CFG_SIZE_W'(256);
         map_cols_ff <= bdt_pkg::CFG_SIZE_W'(256);
         res_ff      <= bdt_pkg::RES_W'(256);
         busy_ff     <= 1'b0;
      end else begin
         map_rows_ff <= map_rows_in;
         map_cols_ff <= map_cols_in;
         res_ff      <= res_in;
         busy_ff     <= busy_in;
      end
   end

   assign busy = busy_ff;

   bdt_ram #(
      .WIDTH (1),
      .DEPTH (bdt_pkg::MEM_DEPTH)
   ) u_mask (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_payload.is_free),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   bdt_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .query   (query),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata),
      .result  (scan_res)
   );

   bdt_root u_root (
      .clock       (clock),
      .reset       (reset),
      .scan        (scan_res),
      .resolution  (res_ff),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy_ff)
      else $error("result strobe outside a query");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("more than one result word for a query");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      accept_query |=> busy_ff && !rsp_valid)
      else $error("query accepted without raising busy");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy_ff && !rsp_valid)
      else $error("not idle after reset");

endmodule
